### hdl/assert_macros.svh
// Assertion macros shared by the point-in-polygon RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pip_pkg.sv
// Shared types and constants for the even-odd point-in-polygon block.
// Used by pip_front, pip_back and the top module; depends on nothing else.
package pip_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FIFO_DEPTH_DEF  = 4;
    localparam int CFG_IDX_W       = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_X = 2'd0,
        REG_QUERY_Y = 2'd1
    } cfg_reg_t;

    // Control flags of one edge record passed from front to back.
    typedef struct packed {
        logic straddle;
        logic last;
    } edge_ctl_t;

    localparam int EDGE_CTL_W = $bits(edge_ctl_t);

endpackage

### hdl/pip_front.sv
// Front end: holds the query point and the previous vertex, forms edges and
// classifies them. Depends on pip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pip_front #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pip_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [COORD_WIDTH-1:0]            cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_WIDTH-1:0]     vert_x,
    input  logic signed [COORD_WIDTH-1:0]     vert_y,
    input  logic                              curve_start,
    input  logic                              last_vertex,
    output logic                              push,
    input  logic                              fifo_full,
    output pip_pkg::edge_ctl_t                edge_ctl,
    output logic signed [COORD_WIDTH:0]       diff_qx,
    output logic signed [COORD_WIDTH:0]       diff_y,
    output logic signed [COORD_WIDTH:0]       diff_x,
    output logic signed [COORD_WIDTH:0]       diff_qy
);

    localparam int DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] query_x_reg;
    logic signed [COORD_WIDTH-1:0] query_y_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg;
    logic signed [COORD_WIDTH-1:0] prev_y_reg;
    logic                          have_prev_reg;
    logic                          have_prev_next;
    logic                          in_xfer;
    logic                          edge_ok;

    assign in_stall = fifo_full;
    assign in_xfer  = in_valid && !fifo_full;
    assign push     = in_xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pip_pkg::REG_QUERY_X: query_x_reg <= cfg_data;
                pip_pkg::REG_QUERY_Y: query_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A last vertex closes the set, so the next vertex opens a fresh one.
    assign have_prev_next = in_xfer ? !last_vertex : have_prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            if (in_xfer)
            begin
                prev_x_reg <= vert_x;
                prev_y_reg <= vert_y;
            end
        end
    end

    assign edge_ok = have_prev_reg && !curve_start;

    // One endpoint strictly above the query y, the other at or below it.
    assign edge_ctl.straddle = edge_ok && ((prev_y_reg > query_y_reg) != (vert_y > query_y_reg));
    assign edge_ctl.last     = last_vertex;

    assign diff_qx = DW'(query_x_reg) - DW'(prev_x_reg);
    assign diff_y  = DW'(vert_y)      - DW'(prev_y_reg);
    assign diff_x  = DW'(vert_x)      - DW'(prev_x_reg);
    assign diff_qy = DW'(query_y_reg) - DW'(prev_y_reg);

    `ASSERT_NEXT(a_last_clears_prev, in_xfer && last_vertex, !have_prev_reg, "previous vertex kept after last vertex")

endmodule

### hdl/pip_fifo.sv
// Short register queue that decouples the edge front end from the back end.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pip_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue fill count beyond depth")
    `ASSERT_IMPLY(a_no_push_full, full, !push, "push offered while queue is full")

endmodule

### hdl/pip_back.sv
// Back end: cross-multiplies each edge record, compares, tracks the parity
// and holds the result register. Depends on pip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pip_back #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fifo_empty,
    output logic                        pop,
    input  pip_pkg::edge_ctl_t          edge_ctl,
    input  logic signed [COORD_WIDTH:0] diff_qx,
    input  logic signed [COORD_WIDTH:0] diff_y,
    input  logic signed [COORD_WIDTH:0] diff_x,
    input  logic signed [COORD_WIDTH:0] diff_qy,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        inside_res
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic                   advance;
    logic                   s1_valid_reg;
    pip_pkg::edge_ctl_t     s1_ctl_reg;
    logic                   s1_dpos_reg;
    logic signed [PW-1:0]   s1_pa_reg;
    logic signed [PW-1:0]   s1_pb_reg;
    logic signed [PW-1:0]   prod_a;
    logic signed [PW-1:0]   prod_b;
    logic                   crosses;
    logic                   parity_reg;
    logic                   parity_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   inside_reg;

    // The pipeline moves unless a finished result is waiting on a stalled output.
    assign advance = !(out_valid_reg && out_stall);
    assign pop     = advance && !fifo_empty;

    assign prod_a = diff_qx * diff_y;
    assign prod_b = diff_x * diff_qy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= !fifo_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_ctl_reg  <= edge_ctl;
            s1_dpos_reg <= !diff_y[DW-1];
            s1_pa_reg   <= prod_a;
            s1_pb_reg   <= prod_b;
        end
    end

    // Multiplying through by the y span flips the comparison when it is negative.
    assign crosses = s1_ctl_reg.straddle &&
                     (s1_dpos_reg ? (s1_pa_reg < s1_pb_reg) : (s1_pb_reg < s1_pa_reg));

    always_comb
    begin
        parity_next    = parity_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance && s1_valid_reg)
        begin
            parity_next = s1_ctl_reg.last ? 1'b0 : (parity_reg ^ crosses);
            if (s1_ctl_reg.last)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && s1_ctl_reg.last)
        begin
            inside_reg <= parity_reg ^ crosses;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

    `ASSERT_IMPLY(a_result_source, $rose(out_valid_reg), $past(s1_valid_reg && s1_ctl_reg.last), "result raised without a last vertex")

endmodule

### hdl/point_in_polygon_even_odd.sv
// Even-odd point-in-polygon test over streamed polyline vertices.
// Throughput: one vertex per cycle while in_stall is low; the edge test is a pair of registered multiplies.
// The last vertex passes through the edge queue and the s1 product registers before out_valid and inside_res are set.
// The edge queue (four entries by default) lets input keep flowing while a result waits on out_stall, until it fills.
// Reset (rst_n low, asynchronous) clears query point, previous vertex, parity and queue.
module point_in_polygon_even_odd #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF,
    parameter int FIFO_DEPTH  = pip_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pip_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] vert_x,
    input  logic signed [COORD_WIDTH-1:0] vert_y,
    input  logic                          curve_start,
    input  logic                          last_vertex,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          inside_res
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int QW = pip_pkg::EDGE_CTL_W + 4 * DW;

    logic                        push;
    logic                        fifo_full;
    logic                        fifo_empty;
    logic                        pop;
    pip_pkg::edge_ctl_t          f_ctl;
    logic signed [DW-1:0]        f_diff_qx;
    logic signed [DW-1:0]        f_diff_y;
    logic signed [DW-1:0]        f_diff_x;
    logic signed [DW-1:0]        f_diff_qy;
    logic [QW-1:0]               push_data;
    logic [QW-1:0]               pop_data;
    pip_pkg::edge_ctl_t          b_ctl;

    pip_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .curve_start (curve_start),
        .last_vertex (last_vertex),
        .push        (push),
        .fifo_full   (fifo_full),
        .edge_ctl    (f_ctl),
        .diff_qx     (f_diff_qx),
        .diff_y      (f_diff_y),
        .diff_x      (f_diff_x),
        .diff_qy     (f_diff_qy)
    );

    assign push_data = {f_ctl, f_diff_qx, f_diff_y, f_diff_x, f_diff_qy};

    pip_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .empty     (fifo_empty),
        .pop_data  (pop_data)
    );

    assign b_ctl = pip_pkg::edge_ctl_t'(pop_data[QW-1 -: pip_pkg::EDGE_CTL_W]);

    pip_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .edge_ctl   (b_ctl),
        .diff_qx    (pop_data[4*DW-1 -: DW]),
        .diff_y     (pop_data[3*DW-1 -: DW]),
        .diff_x     (pop_data[2*DW-1 -: DW]),
        .diff_qy    (pop_data[DW-1:0]),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res)
    );

endmodule

### tb/point_in_polygon_even_odd_test.sv
// Self-checking testbench for the even-odd point-in-polygon block.
// It streams directed and random polyline sets against a local crossing-number predictor.
// Depends on hdl/pip_pkg.sv and hdl/point_in_polygon_even_odd.sv.
module point_in_polygon_even_odd_test;

    localparam int COORD_W = pip_pkg::COORD_WIDTH_DEF;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_W - 1));
    localparam int RANDOM_ITEMS = 1260;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE_CYCLES = 8;

    // Indexes with no register behind them; writes to these must be ignored.
    localparam logic [pip_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [pip_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [pip_pkg::CFG_IDX_W-1:0]   cfg_index = pip_pkg::REG_QUERY_X;
    logic [COORD_W-1:0]              cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic signed [COORD_W-1:0]       vert_x = '0;
    logic signed [COORD_W-1:0]       vert_y = '0;
    logic                            curve_start = 1'b0;
    logic                            last_vertex = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            inside_res;

    // Predictor state: query point mirror and the running edge walk.
    longint query_x_model = 0;
    longint query_y_model = 0;
    longint prev_x_model = 0;
    longint prev_y_model = 0;
    bit     has_prev_model = 1'b0;
    bit     parity_model = 1'b0;
    bit     parity_expected_q[$];

    int fail_count = 0;
    int vertices_sent = 0;
    int results_checked = 0;
    int config_writes = 0;
    int burst_left = 0;
    bit idle_enable = 1'b1;

    stall_mode_t stall_mode = STALL_NONE;
    int          stall_run = 0;
    bit          expected_bit;

    point_in_polygon_even_odd i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .curve_start (curve_start),
        .last_vertex (last_vertex),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .inside_res  (inside_res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Exact crossing test, cross-multiplied by the edge's y extent.
    function automatic bit edge_crosses_ray(longint xa, longint ya, longint xb, longint yb);
        longint dy;
        longint lhs;
        longint rhs;
        if ((ya > query_y_model) == (yb > query_y_model))
            return 1'b0;
        dy  = yb - ya;
        lhs = (query_x_model - xa) * dy;
        rhs = (xb - xa) * (query_y_model - ya);
        return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic longint pick_coord(longint centre, int span_shift);
        logic signed [COORD_W-1:0] raw;
        longint span;
        longint v;
        raw = COORD_W'($urandom());
        if (span_shift >= COORD_W)
            return raw;
        span = longint'(1) <<< span_shift;
        v = centre + longint'($urandom_range(0, 2 * span)) - span;
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v;
    endfunction

    function automatic longint pick_query();
        logic signed [COORD_W-1:0] raw;
        int sel;
        raw = COORD_W'($urandom());
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return COORD_MAX;
        if (sel == 1)
            return COORD_MIN;
        if (sel < 5)
            return longint'($urandom_range(0, 1 << 16)) - (1 << 15);
        return raw;
    endfunction

    // Receiver back-pressure: runs of random length in one of four moods.
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_run  = $urandom_range(4, 48);
        end
        else
            stall_run--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (parity_expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual inside_res=%0b",
                         $time, inside_res);
                fail_count++;
            end
            else
            begin
                expected_bit = parity_expected_q.pop_front();
                if (inside_res !== expected_bit)
                begin
                    $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                             $time, expected_bit, inside_res);
                    fail_count++;
                end
                results_checked++;
            end
        end
    end

    // Every task is entered and left just after a rising edge.
    task automatic send_vertex(input longint x, input longint y, input bit start,
                               input bit last);
        int gap;
        in_valid    <= 1'b1;
        vert_x      <= x[COORD_W-1:0];
        vert_y      <= y[COORD_W-1:0];
        curve_start <= start;
        last_vertex <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        vertices_sent++;
        if (has_prev_model && !start
            && edge_crosses_ray(prev_x_model, prev_y_model, x, y))
            parity_model = !parity_model;
        prev_x_model   = x;
        prev_y_model   = y;
        has_prev_model = 1'b1;
        if (last)
        begin
            parity_expected_q = {parity_expected_q, parity_model};
            prev_x_model   = 0;
            prev_y_model   = 0;
            has_prev_model = 1'b0;
            parity_model   = 1'b0;
        end
        if (idle_enable)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Stop sending until every result is back, then let the pipeline settle.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (parity_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pip_pkg::CFG_IDX_W-1:0] index, input longint value);
        logic [COORD_W-1:0] data;
        data = value[COORD_W-1:0];
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == pip_pkg::REG_QUERY_X)
            query_x_model = longint'($signed(data));
        else if (index == pip_pkg::REG_QUERY_Y)
            query_y_model = longint'($signed(data));
        config_writes++;
        @(posedge clk);
    endtask

    task automatic send_square(input longint half);
        send_vertex(-half, -half, 1'b1, 1'b0);
        send_vertex(half, -half, 1'b0, 1'b0);
        send_vertex(half, half, 1'b0, 1'b0);
        send_vertex(-half, half, 1'b0, 1'b0);
        send_vertex(-half, -half, 1'b0, 1'b1);
    endtask

    // The query point sits at the origin straight out of reset.
    task automatic test_reset_state();
        send_square(256);
        wait_for_results();
    endtask

    task automatic test_first_vertex_rules();
        // The first vertex after a result forms no edge even without curve_start.
        send_vertex(512, -512, 1'b0, 1'b0);
        send_vertex(512, 512, 1'b0, 1'b1);
        // A vertex with both flags forms no edge and emits the parity held so far.
        send_vertex(100, 100, 1'b1, 1'b1);
        send_vertex(512, -512, 1'b1, 1'b0);
        send_vertex(512, 512, 1'b0, 1'b0);
        send_vertex(0, 0, 1'b1, 1'b1);
        wait_for_results();
    endtask

    task automatic test_degenerate_edges();
        // Horizontal edge through the query point.
        send_vertex(-512, 0, 1'b1, 1'b0);
        send_vertex(512, 0, 1'b0, 1'b1);
        // Edge passing exactly through the query point.
        send_vertex(-256, -256, 1'b1, 1'b0);
        send_vertex(256, 256, 1'b0, 1'b1);
        // A vertex lying on the query line counts as below it.
        send_vertex(512, 0, 1'b1, 1'b0);
        send_vertex(512, 512, 1'b0, 1'b0);
        send_vertex(512, -512, 1'b0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_register_index();
        write_reg(CFG_IDX_SPARE_A, pick_query());
        write_reg(CFG_IDX_SPARE_B, pick_query());
        send_square(256);
        wait_for_results();
        write_reg(pip_pkg::REG_QUERY_X, 1024);
        write_reg(pip_pkg::REG_QUERY_Y, 0);
        send_square(256);
        wait_for_results();
    endtask

    task automatic test_extremes();
        write_reg(pip_pkg::REG_QUERY_X, COORD_MAX);
        write_reg(pip_pkg::REG_QUERY_Y, COORD_MIN);
        send_vertex(COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b1);
        wait_for_results();
        write_reg(pip_pkg::REG_QUERY_X, COORD_MIN);
        write_reg(pip_pkg::REG_QUERY_Y, COORD_MAX - 1);
        send_vertex(COORD_MAX, COORD_MIN, 1'b1, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0, 1'b1);
        wait_for_results();
    endtask

    // One set of polylines around the query point, ending on a last vertex.
    task automatic send_polyline_set(input int span_shift, input bit noisy);
        int     n_lines;
        int     n_verts;
        bit     close_it;
        bit     is_final;
        bit     start;
        bit     last;
        longint x;
        longint y;
        longint first_x;
        longint first_y;
        n_lines = $urandom_range(1, 3);
        for (int line = 0; line < n_lines; line++)
        begin
            n_verts  = $urandom_range(2, 8);
            close_it = ($urandom_range(0, 3) != 0);
            for (int v = 0; v < n_verts; v++)
            begin
                x = pick_coord(query_x_model, span_shift);
                y = pick_coord(query_y_model, span_shift);
                if ($urandom_range(0, 9) == 0)
                    y = query_y_model;
                if ($urandom_range(0, 9) == 0)
                    x = query_x_model;
                if (v == 0)
                begin
                    first_x = x;
                    first_y = y;
                end
                is_final = (line == n_lines - 1) && (v == n_verts - 1) && !close_it;
                start = (v == 0) && (line > 0 || $urandom_range(0, 1) == 1);
                last  = is_final;
                if (noisy)
                begin
                    start = ($urandom_range(0, 3) == 0);
                    last  = is_final || ($urandom_range(0, 9) == 0);
                end
                send_vertex(x, y, start, last);
            end
            if (close_it)
            begin
                is_final = (line == n_lines - 1);
                last = is_final || (noisy && $urandom_range(0, 9) == 0);
                send_vertex(first_x, first_y, noisy && $urandom_range(0, 3) == 0, last);
            end
        end
    endtask

    task automatic test_random_sets();
        int span_choice[4];
        int random_start;
        int phase_start;
        span_choice  = '{6, 12, 20, 24};
        random_start = vertices_sent;
        while (vertices_sent - random_start < RANDOM_ITEMS)
        begin
            wait_for_results();
            write_reg(pip_pkg::REG_QUERY_X, pick_query());
            write_reg(pip_pkg::REG_QUERY_Y, pick_query());
            idle_enable = ($urandom_range(0, 3) != 0);
            phase_start = vertices_sent;
            while (vertices_sent - phase_start < PHASE_ITEMS)
            begin
                send_polyline_set(span_choice[$urandom_range(0, 3)],
                                  $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 9) == 0)
                    wait_for_results();
            end
        end
        idle_enable = 1'b1;
        wait_for_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_first_vertex_rules();
        test_degenerate_edges();
        test_register_index();
        test_extremes();
        test_random_sets();
        wait_for_results();
        if (parity_expected_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, parity_expected_q.size());
            fail_count++;
        end
        $display("Sent %0d vertices in directed and random polyline sets, %0d register writes.",
                 vertices_sent, config_writes);
        $display("Checked %0d inside flags under random sender gaps and receiver stalls.",
                 results_checked);
        if (fail_count == 0)
            $display("[point_in_polygon_even_odd] OK");
        else
            $display("[point_in_polygon_even_odd] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: run did not complete in time", $time);
        $display("[point_in_polygon_even_odd] ERROR");
        $finish;
    end

endmodule
